[sv/dms_pkg.sv]
// shared types and constants for the dark marker sync detector
`timescale 1ns / 1ps
package dms_pkg;
  localparam int CenterW = 16;
  localparam int EdgeW   = 17;
  localparam int TotalW  = 36;
  localparam int AvgW    = 16;
  localparam int WinW    = 12;

  typedef enum logic [1:0] {
    CFG_FPS  = 2'd0,
    CFG_QTY  = 2'd1,
    CFG_RWS  = 2'd2,
    CFG_BLK  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_DIV    = 3'd1,
    ST_STORE  = 3'd2,
    ST_SCAN   = 3'd3,
    ST_OUT    = 3'd4
  } back_state_t;

  // per-frame flags the front classifier hands to the back end
  typedef struct packed {
    logic drop;
    logic request;
    logic fast;
    logic marker;
    logic record;
  } frame_flags_t;
endpackage

[sv/dms_front.sv]
// front stage: fall/rise classification, marker tracking and scan control
`timescale 1ns / 1ps
module dms_front #(
  parameter int FRAME_BITS = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [FRAME_BITS-1:0]   in_frame_number,
  input  logic [15:0]             in_center_mean,
  input  logic [16:0]             in_edge_mean_sum,
  input  logic [7:0]              fps,
  input  logic [3:0]              rws,
  input  logic [16:0]             blk,
  input  logic                    q_full,
  output logic                    q_push,
  output dms_pkg::frame_flags_t   q_flags,
  output logic [FRAME_BITS-1:0]   q_first,
  output logic [FRAME_BITS-1:0]   q_last,
  output logic [35:0]             q_total,
  output logic [FRAME_BITS:0]     q_len,
  output logic [11:0]             q_window
);
  logic [15:0]           prev_r, prev_nxt;
  logic                  seen_r, seen_nxt;
  logic                  inm_r, inm_nxt;
  logic [35:0]           tot_r, tot_nxt;
  logic [FRAME_BITS-1:0] mbeg_r, mbeg_nxt;
  logic [FRAME_BITS-1:0] dfr_r, dfr_nxt;
  logic                  fast_r, fast_nxt;
  logic [FRAME_BITS-1:0] rlim_r, rlim_nxt;

  logic        acc;
  logic [11:0] window;
  logic [16:0] p2dn, p2up;
  logic        fall, rise;
  logic [FRAME_BITS:0] len;
  logic        drop, req, rec;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign window   = 12'(rws) * 12'(fps);
  assign p2dn = {1'b0, prev_r - in_center_mean} << 1;
  assign p2up = {1'b0, in_center_mean - prev_r} << 1;
  assign fall = (in_center_mean < prev_r) && (p2dn > {1'b0, prev_r});
  assign rise = (in_center_mean > prev_r) && (p2up > {1'b0, prev_r});

  always_comb begin
    prev_nxt = in_center_mean;
    seen_nxt = seen_r;
    inm_nxt  = inm_r;
    tot_nxt  = tot_r;
    mbeg_nxt = mbeg_r;
    dfr_nxt  = dfr_r;
    fast_nxt = fast_r;
    rlim_nxt = rlim_r;
    drop = 1'b0;
    req  = 1'b0;
    rec  = 1'b0;
    len  = '0;
    if (prev_r != '0) begin
      if (seen_r) begin
        if (!inm_r && in_edge_mean_sum < blk) begin
          inm_nxt  = 1'b1;
          tot_nxt  = '0;
          mbeg_nxt = in_frame_number;
        end
        if (inm_nxt) begin
          if (rise) begin
            len      = {1'b0, in_frame_number} - {1'b0, mbeg_nxt};
            seen_nxt = 1'b0;
            inm_nxt  = 1'b0;
            rec = !len[FRAME_BITS] && (len != '0) &&
                  ({len, 1'b0} > (FRAME_BITS+2)'(fps));
            fast_nxt = 1'b1;
          end else begin
            tot_nxt = ({1'b0, tot_nxt} + 37'(in_center_mean)) > 37'(36'hFFFFFFFFF)
                      ? 36'hFFFFFFFFF : 36'(tot_nxt + 36'(in_center_mean));
          end
        end else if ({1'b0, in_frame_number} >
                     ({1'b0, dfr_r} + (FRAME_BITS+1)'(window))) begin
          fast_nxt = 1'b1;
          seen_nxt = 1'b0;
        end
      end else if (fall) begin
        drop    = 1'b1;
        dfr_nxt = in_frame_number;
        if (!fast_r) seen_nxt = 1'b1;
      end
    end
    if (drop && fast_r && in_frame_number > rlim_r) begin
      rlim_nxt = in_frame_number;
      fast_nxt = 1'b0;
      req      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0; seen_r <= 1'b0; inm_r <= 1'b0; tot_r <= '0;
      mbeg_r <= '0; dfr_r <= '0; fast_r <= 1'b1; rlim_r <= '0;
    end else if (acc) begin
      prev_r <= prev_nxt; seen_r <= seen_nxt; inm_r <= inm_nxt; tot_r <= tot_nxt;
      mbeg_r <= mbeg_nxt; dfr_r <= dfr_nxt; fast_r <= fast_nxt; rlim_r <= rlim_nxt;
    end
  end

  assign q_push   = acc;
  assign q_flags  = '{drop: drop, request: req, fast: fast_nxt, marker: inm_nxt,
                      record: rec};
  assign q_first  = mbeg_nxt;
  assign q_last   = in_frame_number;
  assign q_total  = tot_r;
  assign q_len    = len;
  assign q_window = req ? window : '0;
endmodule

[sv/dms_back.sv]
// back end: serial divide, mark table update and best-mark scan
`timescale 1ns / 1ps
module dms_back #(
  parameter int FRAME_BITS = 20,
  parameter int MAX_MARKS  = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  dms_pkg::frame_flags_t q_flags,
  input  logic [FRAME_BITS-1:0] q_first,
  input  logic [FRAME_BITS-1:0] q_last,
  input  logic [35:0]           q_total,
  input  logic [FRAME_BITS:0]   q_len,
  input  logic [11:0]           q_window,
  input  logic [3:0]            qty,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_drop_detected,
  output logic                  out_rewind_request,
  output logic [11:0]           out_rewind_frames,
  output logic                  out_fast_scan,
  output logic                  out_in_marker,
  output logic                  out_marks_changed,
  output logic                  out_best_valid,
  output logic [FRAME_BITS-1:0] out_best_start,
  output logic [FRAME_BITS-1:0] out_best_end,
  output logic [15:0]           out_best_average
);
  localparam int IW = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;
  localparam int CW = $clog2(MAX_MARKS + 1);
  localparam int DW = 36;
  localparam int LW = FRAME_BITS + 1;

  dms_pkg::back_state_t st_r, st_nxt;

  logic [FRAME_BITS-1:0] mbeg [MAX_MARKS];
  logic [FRAME_BITS-1:0] mfin [MAX_MARKS];
  logic [15:0]           mavg [MAX_MARKS];

  logic [CW-1:0]  cnt_r;
  logic [DW-1:0]  quo_r;
  logic [LW:0]    rem_r;
  logic [5:0]     step_r;
  logic [CW-1:0]  idx_r;
  logic           pick_ok_r, best_ok_r, chg_r;
  logic [IW-1:0]  pick_r;
  logic [15:0]    top_r, bavg_r;
  logic [FRAME_BITS-1:0] bst_r, ben_r;
  logic [15:0]    avg_r;
  dms_pkg::frame_flags_t fl_r;
  logic [FRAME_BITS-1:0] first_r, last_r;
  logic [LW-1:0]  len_r;
  logic [11:0]    win_r;

  logic [CW-1:0]  lim;
  logic [LW:0]    rsh;
  logic           sub_ok;
  logic [IW-1:0]  ix;
  logic           out_take;

  assign lim = ({1'b0, qty} > 5'(MAX_MARKS)) ? CW'(MAX_MARKS) : CW'(qty);
  assign rsh = {rem_r[LW-1:0], quo_r[DW-1]};
  assign sub_ok = rsh >= {1'b0, len_r};
  assign ix = idx_r[IW-1:0];
  assign out_take = out_valid && !out_stall;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      dms_pkg::ST_IDLE:  if (q_valid) st_nxt = dms_pkg::ST_DIV;
      dms_pkg::ST_DIV:   if (!fl_r.record || step_r == 6'(DW)) st_nxt = dms_pkg::ST_STORE;
      dms_pkg::ST_STORE: if (!fl_r.record || cnt_r < lim || idx_r == cnt_r)
                           st_nxt = dms_pkg::ST_SCAN;
      dms_pkg::ST_SCAN:  if (idx_r == cnt_r) st_nxt = dms_pkg::ST_OUT;
      dms_pkg::ST_OUT:   if (out_take) st_nxt = dms_pkg::ST_IDLE;
      default:           st_nxt = dms_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop     = (st_r == dms_pkg::ST_IDLE) && q_valid;
    out_valid = (st_r == dms_pkg::ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= dms_pkg::ST_IDLE;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == dms_pkg::ST_STORE && fl_r.record && cnt_r < lim)
        cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      dms_pkg::ST_IDLE: begin
        fl_r <= q_flags; first_r <= q_first; last_r <= q_last;
        len_r <= q_len; win_r <= q_window; quo_r <= q_total;
        rem_r <= '0; step_r <= '0; idx_r <= '0; chg_r <= 1'b0;
        pick_ok_r <= 1'b0; top_r <= '0; pick_r <= '0;
      end
      dms_pkg::ST_DIV: begin
        if (fl_r.record && step_r != 6'(DW)) begin
          rem_r  <= sub_ok ? rsh - {1'b0, len_r} : rsh;
          quo_r  <= {quo_r[DW-2:0], sub_ok};
          step_r <= step_r + 1'b1;
        end else begin
          avg_r <= (quo_r > 36'hFFFF) ? 16'hFFFF : quo_r[15:0];
        end
      end
      dms_pkg::ST_STORE: begin
        if (fl_r.record) begin
          if (cnt_r < lim) begin
            mbeg[cnt_r[IW-1:0]] <= first_r; mfin[cnt_r[IW-1:0]] <= last_r;
            mavg[cnt_r[IW-1:0]] <= avg_r; chg_r <= 1'b1;
          end else if (idx_r != cnt_r) begin
            if (mavg[ix] > avg_r && mavg[ix] > top_r) begin
              top_r <= mavg[ix]; pick_r <= ix; pick_ok_r <= 1'b1;
            end
            idx_r <= idx_r + 1'b1;
          end
        end
        if (st_nxt == dms_pkg::ST_SCAN) begin
          idx_r <= '0; best_ok_r <= 1'b0; bavg_r <= 16'hFFFF;
          if (pick_ok_r) begin
            mbeg[pick_r] <= first_r; mfin[pick_r] <= last_r;
            mavg[pick_r] <= avg_r; chg_r <= 1'b1;
          end
        end
      end
      dms_pkg::ST_SCAN: begin
        if (idx_r != cnt_r) begin
          if (mavg[ix] != '0 && (!best_ok_r || mavg[ix] < bavg_r)) begin
            bavg_r <= mavg[ix]; bst_r <= mbeg[ix]; ben_r <= mfin[ix];
            best_ok_r <= 1'b1;
          end
          idx_r <= idx_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_drop_detected  = fl_r.drop;
  assign out_rewind_request = fl_r.request;
  assign out_rewind_frames  = win_r;
  assign out_fast_scan      = fl_r.fast;
  assign out_in_marker      = fl_r.marker;
  assign out_marks_changed  = chg_r;
  assign out_best_valid     = best_ok_r;
  assign out_best_start     = best_ok_r ? bst_r : '0;
  assign out_best_end       = best_ok_r ? ben_r : '0;
  assign out_best_average   = best_ok_r ? bavg_r : '0;
endmodule

[sv/dark_marker_sync_detector_unit.sv]
// top level of the dark marker sync detector
`timescale 1ns / 1ps
// a beat with no recorded mark passes through the back end's divide, store, scan and output states
// a recorded mark adds a 36-step serial divide and, on a full table, a replace
// search over the stored marks
// the back end takes the next beat only after the last one's result is taken at the output
// the front classifies a beat per cycle into a two-entry queue, stalling while it is full
// reset: synchronous active-low, control state and config to defaults
module dark_marker_sync_detector_unit #(
  parameter int MAX_MARKS  = 8,
  parameter int FRAME_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [16:0]           cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FRAME_BITS-1:0] in_frame_number,
  input  logic [15:0]           in_center_mean,
  input  logic [16:0]           in_edge_mean_sum,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_drop_detected,
  output logic                  out_rewind_request,
  output logic [11:0]           out_rewind_frames,
  output logic                  out_fast_scan,
  output logic                  out_in_marker,
  output logic                  out_marks_changed,
  output logic                  out_best_valid,
  output logic [FRAME_BITS-1:0] out_best_start,
  output logic [FRAME_BITS-1:0] out_best_end,
  output logic [15:0]           out_best_average
);
  localparam int QW = 5 + 2*FRAME_BITS + 36 + FRAME_BITS + 1 + 12;

  // configuration registers
  logic [7:0]  fps_r;
  logic [3:0]  qty_r, rws_r;
  logic [16:0] blk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fps_r <= 8'd30; qty_r <= 4'd1; rws_r <= 4'd4; blk_r <= 17'd3840;
    end else if (cfg_we) begin
      case (dms_pkg::cfg_idx_t'(cfg_index))
        dms_pkg::CFG_FPS: fps_r <= cfg_wdata[7:0];
        dms_pkg::CFG_QTY: qty_r <= cfg_wdata[3:0];
        dms_pkg::CFG_RWS: rws_r <= cfg_wdata[3:0];
        dms_pkg::CFG_BLK: blk_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front to back queue, two entries
  logic                  q_push, q_pop, q_full, q_valid;
  dms_pkg::frame_flags_t f_flags;
  logic [FRAME_BITS-1:0] f_first, f_last;
  logic [35:0]           f_total;
  logic [FRAME_BITS:0]   f_len;
  logic [11:0]           f_win;
  logic [QW-1:0]         qmem [2];
  logic [QW-1:0]         qhead;
  logic                  wp_r, rp_r;
  logic [1:0]            qn_r;

  dms_front #(.FRAME_BITS(FRAME_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_frame_number, .in_center_mean,
    .in_edge_mean_sum, .fps(fps_r), .rws(rws_r), .blk(blk_r), .q_full,
    .q_push, .q_flags(f_flags), .q_first(f_first), .q_last(f_last),
    .q_total(f_total), .q_len(f_len), .q_window(f_win)
  );

  assign q_full  = qn_r == 2'd2;
  assign q_valid = qn_r != 2'd0;
  assign qhead   = qmem[rp_r];

  always_ff @(posedge clk) begin
    if (q_push) qmem[wp_r] <= {f_flags, f_first, f_last, f_total, f_len, f_win};
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; qn_r <= '0;
    end else begin
      if (q_push) wp_r <= ~wp_r;
      if (q_pop)  rp_r <= ~rp_r;
      qn_r <= qn_r + 2'(q_push) - 2'(q_pop);
    end
  end

  dms_back #(.FRAME_BITS(FRAME_BITS), .MAX_MARKS(MAX_MARKS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop,
    .q_flags(dms_pkg::frame_flags_t'(qhead[QW-1 -: 5])),
    .q_first(qhead[QW-6 -: FRAME_BITS]),
    .q_last(qhead[QW-6-FRAME_BITS -: FRAME_BITS]),
    .q_total(qhead[QW-6-2*FRAME_BITS -: 36]),
    .q_len(qhead[12 +: FRAME_BITS+1]),
    .q_window(qhead[11:0]),
    .qty(qty_r), .out_valid, .out_stall, .out_drop_detected, .out_rewind_request,
    .out_rewind_frames, .out_fast_scan, .out_in_marker, .out_marks_changed,
    .out_best_valid, .out_best_start, .out_best_end, .out_best_average
  );
endmodule

[sv/dms_checker.sv]
// port-level checker for the dark marker sync detector
`timescale 1ns / 1ps
module dms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_rewind_request,
  input logic [11:0] out_rewind_frames,
  input logic        out_fast_scan,
  input logic        out_best_valid,
  input logic [15:0] out_best_average
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_req_slow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rewind_request |-> !out_fast_scan) else $error("rewind kept fast");
  a_win: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rewind_request |-> out_rewind_frames == '0) else $error("stray window");
  a_best: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_best_valid == (out_best_average != '0))) else $error("best flag");
endmodule

bind dark_marker_sync_detector_unit dms_checker u_chk (
  .clk, .rst_n, .out_valid, .out_stall, .out_rewind_request, .out_rewind_frames,
  .out_fast_scan, .out_best_valid, .out_best_average
);
